// ===== rtl/core/pva_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polar vector adder package
// Formats, scaling constants and the CORDIC arctangent table shared by the
// polar vector adder.
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int CORDIC_STEPS_DEF = 20;

	localparam int COORD_W = 52;
	localparam int ANG_W = 34;

	localparam int DEG360 = 23592960;
	localparam int DEG180 = 11796480;
	localparam int DEG90 = 5898240;
	localparam int HALF_PI_Q30 = 1686629713;

	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131497;
	localparam logic [34:0] RAD_PER_DEG_Q40 = 35'd19190098069;
	localparam logic [30:0] DEG_PER_RAD_Q25 = 31'd1922527338;
	localparam logic [32:0] LEN_MAX = 33'h1_FFFF_FFFF;

	localparam logic [17:0] MOD360_OFFSET = 18'd33120;
	localparam logic [16:0] MOD360_RECIP = 17'd93207;
	localparam int MOD360_SHIFT = 25;

	typedef enum logic [1:0] {
		QUAD_MID,
		QUAD_POS,
		QUAD_NEG
	} quad_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] val;
		case (idx)
			5'd0: val = 30'd843314857;
			5'd1: val = 30'd497837829;
			5'd2: val = 30'd263043837;
			5'd3: val = 30'd133525159;
			5'd4: val = 30'd67021687;
			5'd5: val = 30'd33543516;
			5'd6: val = 30'd16775851;
			5'd7: val = 30'd8388437;
			5'd8: val = 30'd4194283;
			5'd9: val = 30'd2097149;
			5'd10: val = 30'd1048576;
			5'd11: val = 30'd524288;
			5'd12: val = 30'd262144;
			5'd13: val = 30'd131072;
			5'd14: val = 30'd65536;
			5'd15: val = 30'd32768;
			5'd16: val = 30'd16384;
			5'd17: val = 30'd8192;
			5'd18: val = 30'd4096;
			5'd19: val = 30'd2048;
			5'd20: val = 30'd1024;
			5'd21: val = 30'd512;
			5'd22: val = 30'd256;
			5'd23: val = 30'd128;
			5'd24: val = 30'd64;
			5'd25: val = 30'd32;
			5'd26: val = 30'd16;
			5'd27: val = 30'd8;
			5'd28: val = 30'd4;
			5'd29: val = 30'd2;
			5'd30: val = 30'd1;
			default: val = 30'd0;
		endcase
		return val;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/polar_vector_adder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polar vector adder
// Adds two vectors given as Q16.16 length and Q16.16 degrees and returns the
// length and angle of the sum through rotation and vectoring CORDIC chains.
// ----------------------------------------------------------------------------
// The block takes one vector pair in every cycle while item_stall is low
// and returns each result in order; the pipeline is made of the two CORDIC
// chains, each of which spends one pipeline stage on every iteration, plus
// eight stages for angle reduction, scaling, summing and rounding. A stalled
// result holds the whole pipeline only while the last stage is occupied;
// while that stage is empty the pipeline still advances.
module polar_vector_adder #(
	parameter int CORDIC_STEPS = pva_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [31:0]        first_length,
	input  logic signed [31:0] first_angle,
	input  logic [31:0]        second_length,
	input  logic signed [31:0] second_angle,
	output logic               sum_valid,
	input  logic               sum_stall,
	output logic [32:0]        sum_length,
	output logic signed [24:0] sum_angle
);

	localparam int W = pva_pkg::COORD_W;
	localparam int ZW = pva_pkg::ANG_W;
	localparam int NPIPE = 2 * CORDIC_STEPS + 7;

	logic [NPIPE-1:0] vld_q;
	logic sum_valid_q;
	logic en;

	logic [31:0] len_in [2];
	logic [31:0] ang_in [2];
	logic signed [W-1:0] lane_x [2];
	logic signed [W-1:0] lane_y [2];

	assign len_in[0] = first_length;
	assign len_in[1] = second_length;
	assign ang_in[0] = first_angle;
	assign ang_in[1] = second_angle;

	assign en = !(vld_q[NPIPE-1] && sum_valid_q && sum_stall);
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NPIPE-2:0], item_valid};
		end
	end

	for (genvar v = 0; v < 2; v++) begin : g_lane
		logic [17:0] hp_sum;
		logic [33:0] qprod;
		logic [16:0] hp_s1;
		logic [8:0] q_s1;
		logic [15:0] lo_s1;
		logic [45:0] ph_s1;
		logic [49:0] pl_s1;

		logic [16:0] rem;
		logic [24:0] frac;
		logic signed [25:0] ang_red;
		pva_pkg::quad_t quad;
		logic signed [23:0] res;
		pva_pkg::quad_t quad_s2;
		logic signed [23:0] res_s2;
		logic [46:0] m_s2;

		logic [23:0] res_neg;
		pva_pkg::quad_t quad_s3;
		logic zneg_s3;
		logic [57:0] zp_s3;
		logic [46:0] m_s3;

		logic [57:0] zp_rnd;
		logic signed [W-1:0] rx_s [CORDIC_STEPS+1];
		logic signed [W-1:0] ry_s [CORDIC_STEPS+1];
		logic signed [ZW-1:0] rz_s [CORDIC_STEPS+1];

		always_comb begin
			hp_sum = 18'($signed(ang_in[v][31:16])) + pva_pkg::MOD360_OFFSET;
			qprod = 34'(hp_sum[16:0]) * 34'(pva_pkg::MOD360_RECIP);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hp_s1 <= hp_sum[16:0];
				q_s1 <= qprod[pva_pkg::MOD360_SHIFT +: 9];
				lo_s1 <= ang_in[v][15:0];
				ph_s1 <= 46'(len_in[v][31:18]) * 46'(pva_pkg::INV_GAIN_Q32);
				pl_s1 <= 50'(len_in[v][17:0]) * 50'(pva_pkg::INV_GAIN_Q32);
			end
		end

		always_comb begin
			rem = hp_s1 - 17'(q_s1) * 17'd360;
			frac = {rem[8:0], lo_s1};
			if (26'(frac) > 26'(pva_pkg::DEG180)) begin
				ang_red = 26'(frac) - 26'(pva_pkg::DEG360);
			end else begin
				ang_red = 26'(frac);
			end
			if (ang_red > 26'(pva_pkg::DEG90)) begin
				quad = pva_pkg::QUAD_POS;
				res = 24'(ang_red - 26'(pva_pkg::DEG90));
			end else if (ang_red < -26'(pva_pkg::DEG90)) begin
				quad = pva_pkg::QUAD_NEG;
				res = 24'(ang_red + 26'(pva_pkg::DEG90));
			end else begin
				quad = pva_pkg::QUAD_MID;
				res = 24'(ang_red);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s2 <= quad;
				res_s2 <= res;
				m_s2 <= 47'(ph_s1) + 47'((pl_s1 + 50'd131072) >> 18);
			end
		end

		assign res_neg = -res_s2;

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s3 <= quad_s2;
				zneg_s3 <= res_s2[23];
				m_s3 <= m_s2;
				if (res_s2[23]) begin
					zp_s3 <= 58'(res_neg[22:0]) * 58'(pva_pkg::RAD_PER_DEG_Q40);
				end else begin
					zp_s3 <= 58'(res_s2[22:0]) * 58'(pva_pkg::RAD_PER_DEG_Q40);
				end
			end
		end

		assign zp_rnd = (zp_s3 + 58'd33554432) >> 26;

		always_ff @(posedge clk) begin
			if (en) begin
				if (zneg_s3) begin
					rz_s[0] <= -ZW'(zp_rnd);
				end else begin
					rz_s[0] <= ZW'(zp_rnd);
				end
				case (quad_s3)
					pva_pkg::QUAD_POS: begin
						rx_s[0] <= '0;
						ry_s[0] <= W'(m_s3);
					end
					pva_pkg::QUAD_NEG: begin
						rx_s[0] <= '0;
						ry_s[0] <= -W'(m_s3);
					end
					default: begin
						rx_s[0] <= W'(m_s3);
						ry_s[0] <= '0;
					end
				endcase
			end
		end

		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					if (!rz_s[i][ZW-1]) begin
						rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
						ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
						rz_s[i+1] <= rz_s[i] - ZW'(pva_pkg::atan_q30(5'(i)));
					end else begin
						rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
						ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
						rz_s[i+1] <= rz_s[i] + ZW'(pva_pkg::atan_q30(5'(i)));
					end
				end
			end
		end

		assign lane_x[v] = rx_s[CORDIC_STEPS];
		assign lane_y[v] = ry_s[CORDIC_STEPS];
	end

	logic signed [W-1:0] sx_s5;
	logic signed [W-1:0] sy_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s5 <= lane_x[0] + lane_x[1];
			sy_s5 <= lane_y[0] + lane_y[1];
		end
	end

	logic signed [W-1:0] vx_s [CORDIC_STEPS+1];
	logic signed [W-1:0] vy_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] vz_s [CORDIC_STEPS+1];
	logic vzero_s [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			vzero_s[0] <= (sx_s5 == '0) && (sy_s5 == '0);
			if (sx_s5 < 0) begin
				if (sy_s5 >= 0) begin
					vx_s[0] <= sy_s5;
					vy_s[0] <= -sx_s5;
					vz_s[0] <= ZW'(pva_pkg::HALF_PI_Q30);
				end else begin
					vx_s[0] <= -sy_s5;
					vy_s[0] <= sx_s5;
					vz_s[0] <= -ZW'(pva_pkg::HALF_PI_Q30);
				end
			end else begin
				vx_s[0] <= sx_s5;
				vy_s[0] <= sy_s5;
				vz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				vzero_s[i+1] <= vzero_s[i];
				if (vy_s[i] > 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + ZW'(pva_pkg::atan_q30(5'(i)));
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - ZW'(pva_pkg::atan_q30(5'(i)));
				end
			end
		end
	end

	logic signed [W-1:0] xf;
	logic signed [ZW-1:0] zf;
	logic [ZW-1:0] zf_neg;
	logic [63:0] plo_s7;
	logic [51:0] phi_s7;
	logic [63:0] pang_s7;
	logic pos_s7;
	logic zneg_s7;
	logic zero_s7;

	assign xf = vx_s[CORDIC_STEPS];
	assign zf = vz_s[CORDIC_STEPS];
	assign zf_neg = -zf;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s7 <= xf > 0;
			zneg_s7 <= zf[ZW-1];
			zero_s7 <= vzero_s[CORDIC_STEPS];
			plo_s7 <= 64'(xf[31:0]) * 64'(pva_pkg::INV_GAIN_Q32);
			phi_s7 <= 52'(xf[W-1:32]) * 52'(pva_pkg::INV_GAIN_Q32);
			if (zf[ZW-1]) begin
				pang_s7 <= 64'(zf_neg[32:0]) * 64'(pva_pkg::DEG_PER_RAD_Q25);
			end else begin
				pang_s7 <= 64'(zf[32:0]) * 64'(pva_pkg::DEG_PER_RAD_Q25);
			end
		end
	end

	logic [52:0] len_full;
	logic [39:0] len_rnd;
	logic [32:0] len_out;
	logic [64:0] ang_sum;
	logic signed [26:0] ang_deg;
	logic signed [24:0] ang_out;
	logic [32:0] sum_length_q;
	logic signed [24:0] sum_angle_q;

	always_comb begin
		len_full = 53'(phi_s7) + 53'((65'(plo_s7) + 65'h8000_0000) >> 32);
		len_rnd = 40'((len_full + 53'd8192) >> 14);
		if (!pos_s7) begin
			len_out = '0;
		end else if (len_rnd > 40'(pva_pkg::LEN_MAX)) begin
			len_out = pva_pkg::LEN_MAX;
		end else begin
			len_out = len_rnd[32:0];
		end
		ang_sum = (65'(pang_s7) + 65'h40_0000_0000) >> 39;
		if (zneg_s7) begin
			ang_deg = -27'(ang_sum[25:0]);
		end else begin
			ang_deg = 27'(ang_sum[25:0]);
		end
		if (ang_deg > 27'(pva_pkg::DEG180) || ang_deg <= -27'(pva_pkg::DEG180)) begin
			ang_out = 25'(pva_pkg::DEG180);
		end else begin
			ang_out = 25'(ang_deg);
		end
		if (zero_s7) begin
			len_out = '0;
			ang_out = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (!sum_valid_q || !sum_stall) begin
			sum_valid_q <= vld_q[NPIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (!sum_valid_q || !sum_stall) begin
			sum_length_q <= len_out;
			sum_angle_q <= ang_out;
		end
	end

	assign sum_valid = sum_valid_q;
	assign sum_length = sum_length_q;
	assign sum_angle = sum_angle_q;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> (sum_angle <= 25'(pva_pkg::DEG180) &&
			sum_angle > -25'(pva_pkg::DEG180)))
		else $error("Result angle lies outside the half-open range.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (sum_valid && sum_stall && vld_q[NPIPE-1]))
		else $error("Input stalled without a blocked result.");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NPIPE-1] && item_stall) |=> vld_q[NPIPE-1])
		else $error("Last pipeline stage lost a transaction while stalled.");

endmodule
`default_nettype wire

// ===== tb/sv/polar_vector_adder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polar vector adder testbench
// Sends vector pairs with random gaps, stalls the result side at random and
// compares every sum length and angle with a fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
module polar_vector_adder_tb;

	localparam int STEPS = 20;
	localparam int LATENCY = 2 * STEPS + 8;
	localparam int IDLE_LIMIT = 5000;
	localparam int REPORT_MAX = 10;

	localparam longint ARCTAN_TAB [STEPS] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048
	};

	typedef struct {
		logic [32:0]        length;
		logic signed [24:0] angle;
	} vec_sum_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [31:0]        first_length = '0;
	logic signed [31:0] first_angle = '0;
	logic [31:0]        second_length = '0;
	logic signed [31:0] second_angle = '0;
	logic               sum_valid;
	logic               sum_stall = 1'b0;
	logic [32:0]        sum_length;
	logic signed [24:0] sum_angle;

	vec_sum_t expected_sums[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	int       stall_left = 0;
	bit       no_gaps = 1'b0;

	polar_vector_adder #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.first_length(first_length),
		.first_angle(first_angle),
		.second_length(second_length),
		.second_angle(second_angle),
		.sum_valid(sum_valid),
		.sum_stall(sum_stall),
		.sum_length(sum_length),
		.sum_angle(sum_angle)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned gain_scale(input longint unsigned a);
		longint unsigned g;
		g = 64'(pva_pkg::INV_GAIN_Q32);
		return (a >> 32) * g + ((((a & 64'hFFFF_FFFF) * g) + 64'h8000_0000) >> 32);
	endfunction

	function automatic longint round_away(input longint v, input int s);
		longint unsigned m;
		m = v < 0 ? longint'(-v) : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	task automatic to_cartesian(input logic [31:0] len, input logic signed [31:0] ang,
			output longint x, output longint y);
		longint a, m, z, t, dx, dy;
		a = longint'(ang) % pva_pkg::DEG360;
		if (a > pva_pkg::DEG180)
			a -= pva_pkg::DEG360;
		if (a <= -pva_pkg::DEG180)
			a += pva_pkg::DEG360;
		m = longint'(gain_scale({18'd0, len, 14'd0}));
		if (a > pva_pkg::DEG90) begin
			x = 0; y = m; a -= pva_pkg::DEG90;
		end else if (a < -pva_pkg::DEG90) begin
			x = 0; y = -m; a += pva_pkg::DEG90;
		end else begin
			x = m; y = 0;
		end
		z = round_away(a * longint'(pva_pkg::RAD_PER_DEG_Q40), 26);
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				t = x - dx; y = y + dy; z -= ARCTAN_TAB[i];
			end else begin
				t = x + dx; y = y - dy; z += ARCTAN_TAB[i];
			end
			x = t;
		end
	endtask

	task automatic predict_sum(input logic [31:0] l1, input logic signed [31:0] a1,
			input logic [31:0] l2, input logic signed [31:0] a2, output vec_sum_t res);
		longint x1, y1, x2, y2, x, y, z, t, dx, dy, d;
		longint unsigned len, m;
		to_cartesian(l1, a1, x1, y1);
		to_cartesian(l2, a2, x2, y2);
		x = x1 + x2;
		y = y1 + y2;
		if (x == 0 && y == 0) begin
			res.length = '0;
			res.angle = '0;
			return;
		end
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = pva_pkg::HALF_PI_Q30;
			end else begin
				t = -y; y = x; x = t; z = -pva_pkg::HALF_PI_Q30;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				t = x + dx; y = y - dy; z += ARCTAN_TAB[i];
			end else begin
				t = x - dx; y = y + dy; z -= ARCTAN_TAB[i];
			end
			x = t;
		end
		len = x > 0 ? gain_scale(x) : 0;
		len = (len + 8192) >> 14;
		if (len > 64'(pva_pkg::LEN_MAX))
			len = 64'(pva_pkg::LEN_MAX);
		m = (z < 0 ? longint'(-z) : z) * 64'(pva_pkg::DEG_PER_RAD_Q25);
		m = (m + (64'd1 << 38)) >> 39;
		d = z < 0 ? -longint'(m) : longint'(m);
		if (d > pva_pkg::DEG180 || d <= -pva_pkg::DEG180)
			d = pva_pkg::DEG180;
		res.length = len[32:0];
		res.angle = d[24:0];
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	task automatic send_pair(input logic [31:0] l1, input logic signed [31:0] a1,
			input logic [31:0] l2, input logic signed [31:0] a2);
		vec_sum_t res;
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_length <= l1;
		first_angle <= a1;
		second_length <= l2;
		second_angle <= a2;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_sum(l1, a1, l2, a2, res);
		expected_sums.push_back(res);
	endtask

	task automatic wait_for_sums();
		item_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		vec_sum_t exp_sum;
		if (item_valid && !item_stall || sum_valid && !sum_stall)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (sum_valid && !sum_stall) begin
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("Unexpected result: length %0d angle %0d", sum_length, sum_angle);
			end else begin
				exp_sum = expected_sums.pop_front();
				if (sum_length !== exp_sum.length || sum_angle !== exp_sum.angle) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("Mismatch: expected length %0d angle %0d, got length %0d angle %0d",
							exp_sum.length, exp_sum.angle, sum_length, sum_angle);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			sum_stall <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			sum_stall <= 1'b0;
		end
	end

	task automatic test_directed();
		logic [31:0] lmax;
		lmax = 32'hFFFF_FFFF;
		send_pair(0, 0, 0, 0);
		send_pair(lmax, 0, lmax, 0);
		send_pair(lmax, 32'sh7FFF_FFFF, lmax, 32'sh8000_0000);
		send_pair(lmax, pva_pkg::DEG90, lmax, pva_pkg::DEG90);
		send_pair(lmax, -pva_pkg::DEG90, 0, 0);
		send_pair(32'h0001_0000, pva_pkg::DEG180, 0, 0);
		send_pair(32'h0001_0000, -pva_pkg::DEG180, 0, pva_pkg::DEG180);
		send_pair(32'h0001_0000, pva_pkg::DEG360, 32'h0001_0000, -pva_pkg::DEG360);
		send_pair(32'h0001_0000, 0, 32'h0001_0000, pva_pkg::DEG180);
		send_pair(32'h0001_0000, pva_pkg::DEG90, 32'h0001_0000, -pva_pkg::DEG90);
		send_pair(32'h0001_0000, pva_pkg::DEG90 + 1, 32'h0002_0000, -pva_pkg::DEG90 - 1);
		send_pair(1, pva_pkg::DEG180 - 1, 1, pva_pkg::DEG180 + 1);
		send_pair(lmax, pva_pkg::DEG180 + 1, lmax, pva_pkg::DEG180 - 1);
		send_pair(32'h0001_0000, 5 * pva_pkg::DEG360 + pva_pkg::DEG180, 0, 0);
		send_pair(32'h0005_0000, 3 * pva_pkg::DEG90, 32'h0005_0000, -3 * pva_pkg::DEG90);
		send_pair(1, 0, 0, 0);
		send_pair(lmax, 32'sh8000_0000, 1, 32'sh7FFF_FFFF);
	endtask

	task automatic test_random_pairs(input int count);
		logic [31:0] l1, l2;
		logic signed [31:0] a1, a2;
		for (int n = 0; n < count; n++) begin
			l1 = $urandom();
			l2 = $urandom();
			a1 = $urandom();
			a2 = $urandom();
			case ($urandom_range(0, 4))
				0: begin
					l1 = l1 >> $urandom_range(0, 31);
					l2 = l2 >> $urandom_range(0, 31);
				end
				1: begin
					a1 = $signed($urandom_range(0, 600)) * pva_pkg::DEG90
						- 300 * pva_pkg::DEG90;
					a2 = a1 + pva_pkg::DEG180;
					l2 = l1;
				end
				2: begin
					a1 = $signed($urandom_range(0, 2 * pva_pkg::DEG360)) - pva_pkg::DEG360;
					a2 = $signed($urandom_range(0, 2 * pva_pkg::DEG360)) - pva_pkg::DEG360;
				end
				default: ;
			endcase
			send_pair(l1, a1, l2, a2);
		end
	endtask

	task automatic test_back_to_back(input int count);
		no_gaps = 1'b1;
		test_random_pairs(count);
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_pairs(800);
		wait_for_sums();
		@(posedge clk);
		test_back_to_back(300);
		test_random_pairs(800);
		wait_for_sums();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_sums.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
